// File: rtl/core/ols_pkg.sv
// Package for the owner-locked LIFO stack: operation and status codes,
// default sizes, and the command and status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ols_pkg;

	localparam int DefStackDepth = 64;
	localparam int DefIdWidth    = 8;
	localparam int WordWidth     = 32;
	localparam int OpWidth       = 2;
	localparam int StatusWidth   = 3;

	typedef enum logic [OpWidth-1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_LOCK   = 2'd2,
		OP_UNLOCK = 2'd3
	} op_t;

	typedef enum logic [StatusWidth-1:0] {
		ST_OK        = 3'd0,
		ST_OTHER     = 3'd1,
		ST_ALREADY   = 3'd2,
		ST_NOTLOCKED = 3'd3,
		ST_OVERFLOW  = 3'd4,
		ST_UNDERFLOW = 3'd5
	} status_t;

	typedef struct packed {
		logic exec;
		logic load_pop;
	} cmd_t;

	typedef struct packed {
		logic pop_hit;
	} stat_t;

endpackage
`default_nettype wire

// File: rtl/core/owner_locked_lifo_stack.sv
// Top level of the owner-locked LIFO stack: stream ports, field packing, and
// the controller and datapath instances. Depends on ols_pkg, ols_ctrl, ols_datapath.
`timescale 1ns / 1ps
`default_nettype none
// Each transaction on the input stream is one push, pop, lock or unlock and
// yields exactly one result transaction, in order. Push, lock, unlock and any
// refused operation show their result in the next cycle; a successful pop waits in
// the READ state, as the stack memory read port is registered. A new transaction
// is accepted in the cycle the result register is empty or is being taken, except
// in the read cycle of a successful pop, when the input is held off. Overflow and
// underflow leave the stack unchanged, and a pop refused by the lock returns -1.
module owner_locked_lifo_stack #(
	parameter int STACK_DEPTH = ols_pkg::DefStackDepth,
	parameter int ID_WIDTH    = ols_pkg::DefIdWidth,
	localparam int CNT_W      = $clog2(STACK_DEPTH + 1),
	localparam int ADDR_W     = $clog2(STACK_DEPTH),
	localparam int IN_W       = ((ID_WIDTH + ols_pkg::WordWidth + 7) / 8) * 8,
	localparam int OUT_W      = ((ols_pkg::WordWidth + 1 + ID_WIDTH + CNT_W + 7) / 8) * 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output      logic                            s_axis_tready,
	// From bit 0: requester_id, push_value.
	input  wire logic [IN_W-1:0]                 s_axis_tdata,
	// From bit 0: op.
	input  wire logic [ols_pkg::OpWidth-1:0]     s_axis_tuser,
	output      logic                            m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// From bit 0: pop_value, is_locked, owner, fill_level, zero fill.
	output      logic [OUT_W-1:0]                m_axis_tdata,
	// From bit 0: status.
	output      logic [ols_pkg::StatusWidth-1:0] m_axis_tuser
);

	ols_pkg::cmd_t  cmd;
	ols_pkg::stat_t stat;

	logic signed [ols_pkg::WordWidth-1:0] pop_value;
	logic                                 is_locked;
	logic [ID_WIDTH-1:0]                  owner;
	logic [CNT_W-1:0]                     fill_level;

	ols_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.stat      (stat)
	);

	ols_datapath #(
		.STACK_DEPTH (STACK_DEPTH),
		.ID_WIDTH    (ID_WIDTH),
		.CNT_W       (CNT_W),
		.ADDR_W      (ADDR_W)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.op           (ols_pkg::op_t'(s_axis_tuser)),
		.requester_id (s_axis_tdata[ID_WIDTH-1:0]),
		.push_value   (s_axis_tdata[ID_WIDTH +: ols_pkg::WordWidth]),
		.pop_value    (pop_value),
		.status       (m_axis_tuser),
		.is_locked    (is_locked),
		.owner        (owner),
		.fill_level   (fill_level)
	);

	assign m_axis_tdata = OUT_W'({fill_level, owner, is_locked, pop_value});

endmodule
`default_nettype wire

// File: rtl/core/ols_datapath.sv
// Datapath of the owner-locked LIFO stack: stack memory, fill count, lock
// registers, operation decode and the result register. Depends on ols_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ols_datapath #(
	parameter int STACK_DEPTH = ols_pkg::DefStackDepth,
	parameter int ID_WIDTH    = ols_pkg::DefIdWidth,
	parameter int CNT_W       = $clog2(STACK_DEPTH + 1),
	parameter int ADDR_W      = $clog2(STACK_DEPTH)
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire ols_pkg::cmd_t                       cmd,
	output      ols_pkg::stat_t                      stat,
	input  wire ols_pkg::op_t                        op,
	input  wire logic [ID_WIDTH-1:0]                 requester_id,
	input  wire logic signed [ols_pkg::WordWidth-1:0] push_value,
	output      logic signed [ols_pkg::WordWidth-1:0] pop_value,
	output      logic [ols_pkg::StatusWidth-1:0]     status,
	output      logic                                is_locked,
	output      logic [ID_WIDTH-1:0]                 owner,
	output      logic [CNT_W-1:0]                    fill_level
);

	logic [ols_pkg::WordWidth-1:0] mem [STACK_DEPTH];

	logic [CNT_W-1:0]    top_q;
	logic                lock_q;
	logic [ID_WIDTH-1:0] owner_q;
	logic [ADDR_W-1:0]   rd_addr_q;

	logic [ols_pkg::WordWidth-1:0]   res_pop_q;
	ols_pkg::status_t                res_status_q;
	logic                            res_lock_q;
	logic [ID_WIDTH-1:0]             res_owner_q;
	logic [CNT_W-1:0]                res_fill_q;

	logic                          allowed;
	logic                          full;
	logic                          empty;
	logic [CNT_W-1:0]              top_inc;
	logic [CNT_W-1:0]              top_dec;
	logic [CNT_W-1:0]              top_d;
	logic                          lock_d;
	logic [ID_WIDTH-1:0]           owner_d;
	ols_pkg::status_t              status_d;
	logic [ols_pkg::WordWidth-1:0] popc_d;
	logic                          wr_en;
	logic                          pop_hit;

	assign allowed = !lock_q || (requester_id == owner_q);
	assign full    = (top_q == CNT_W'(STACK_DEPTH));
	assign empty   = (top_q == '0);
	assign top_inc = top_q + CNT_W'(1);
	assign top_dec = top_q - CNT_W'(1);

	always_comb begin
		top_d    = top_q;
		lock_d   = lock_q;
		owner_d  = owner_q;
		status_d = ols_pkg::ST_OK;
		popc_d   = '0;
		wr_en    = 1'b0;
		pop_hit  = 1'b0;
		case (op)
			ols_pkg::OP_PUSH: begin
				if (full) begin
					status_d = ols_pkg::ST_OVERFLOW;
				end else if (!allowed) begin
					status_d = ols_pkg::ST_OTHER;
				end else begin
					wr_en = 1'b1;
					top_d = top_inc;
				end
			end
			ols_pkg::OP_POP: begin
				if (!allowed) begin
					status_d = ols_pkg::ST_OTHER;
					popc_d   = '1;
				end else if (empty) begin
					status_d = ols_pkg::ST_UNDERFLOW;
				end else begin
					pop_hit = 1'b1;
					top_d   = top_dec;
				end
			end
			ols_pkg::OP_LOCK: begin
				if (!lock_q) begin
					lock_d  = 1'b1;
					owner_d = requester_id;
				end else begin
					status_d = ols_pkg::ST_ALREADY;
				end
			end
			ols_pkg::OP_UNLOCK: begin
				if (!lock_q) begin
					status_d = ols_pkg::ST_NOTLOCKED;
				end else if (requester_id == owner_q) begin
					lock_d = 1'b0;
				end else begin
					status_d = ols_pkg::ST_OTHER;
				end
			end
			default: begin
				status_d = ols_pkg::ST_OK;
			end
		endcase
	end

	assign stat.pop_hit = pop_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q   <= '0;
			lock_q  <= 1'b0;
			owner_q <= '0;
		end else if (cmd.exec) begin
			top_q   <= top_d;
			lock_q  <= lock_d;
			owner_q <= owner_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) begin
			mem[top_q[ADDR_W-1:0]] <= push_value;
		end
		if (cmd.exec) begin
			rd_addr_q    <= top_dec[ADDR_W-1:0];
			res_status_q <= status_d;
			res_lock_q   <= lock_d;
			res_owner_q  <= owner_d;
			res_fill_q   <= top_d;
		end
		if (cmd.load_pop) begin
			res_pop_q <= mem[rd_addr_q];
		end else if (cmd.exec) begin
			res_pop_q <= popc_d;
		end
	end

	assign pop_value  = res_pop_q;
	assign status     = res_status_q;
	assign is_locked  = res_lock_q;
	assign owner      = res_owner_q;
	assign fill_level = res_fill_q;

endmodule
`default_nettype wire

// File: rtl/core/ols_ctrl.sv
// Controller of the owner-locked LIFO stack: transaction handshakes, the
// memory read wait for pops, and result valid. Depends on ols_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ols_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output      logic           in_ready,
	output      logic           out_valid,
	input  wire logic           out_ready,
	output      ols_pkg::cmd_t  cmd,
	input  wire ols_pkg::stat_t stat
);

	typedef enum logic {
		IDLE,
		READ
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   exec;

	assign in_ready     = (state_q == IDLE) && (!out_valid_q || out_ready);
	assign exec         = in_valid && in_ready;
	assign cmd.exec     = exec;
	assign cmd.load_pop = (state_q == READ);
	assign out_valid    = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				IDLE: begin
					if (exec && stat.pop_hit) begin
						state_q     <= READ;
						out_valid_q <= 1'b0;
					end else if (exec) begin
						out_valid_q <= 1'b1;
					end else if (out_ready) begin
						out_valid_q <= 1'b0;
					end
				end
				READ: begin
					state_q     <= IDLE;
					out_valid_q <= 1'b1;
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	a_pop_waits: assert property (@(posedge clk) disable iff (!arst_n)
		exec && stat.pop_hit |=> state_q == READ && !out_valid_q)
		else $error("Successful pop did not enter the read wait.");

	a_fast_result: assert property (@(posedge clk) disable iff (!arst_n)
		exec && !stat.pop_hit |=> out_valid_q && state_q == IDLE)
		else $error("Result of a single-cycle transaction was not presented.");

	a_read_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == READ |=> state_q == IDLE && out_valid_q)
		else $error("Read wait did not finish with a result.");

	a_no_accept_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == READ |-> !cmd.exec)
		else $error("Transaction accepted during the read wait.");

endmodule
`default_nettype wire
